@@ rtl/vtp_pkg.sv @@
// Shared widths, register indexes and defaults for the vertex transform and projection core.
package vtp_pkg;

    localparam int SCREEN_WIDTH_DEF  = 320;
    localparam int SCREEN_HEIGHT_DEF = 240;

    localparam int VERT_W  = 16;
    localparam int COEF_W  = 16;
    localparam int PROD_W  = VERT_W + COEF_W;
    localparam int TRANS_W = 16 + 12;
    localparam int CAM_W   = 34;
    localparam int PROJ_W  = COEF_W + CAM_W;
    localparam int NDC_W   = PROJ_W + 2;
    localparam int Q_BITS  = 15;
    localparam int CFG_W   = 64;
    localparam int IDX_W   = 3;

    localparam logic signed [CAM_W-1:0] NEAR_Q20 = CAM_W'(-13 * 4096);

    localparam logic [IDX_W-1:0] CFG_WORLD_ROW_0 = 3'd0;
    localparam logic [IDX_W-1:0] CFG_WORLD_ROW_1 = 3'd1;
    localparam logic [IDX_W-1:0] CFG_WORLD_ROW_2 = 3'd2;
    localparam logic [IDX_W-1:0] CFG_PROJ_XY     = 3'd3;
    localparam logic [IDX_W-1:0] CFG_PROJ_W      = 3'd4;

    localparam logic [CFG_W-1:0] WORLD_ROW_0_RST = 64'h0000_0000_0000_1000;
    localparam logic [CFG_W-1:0] WORLD_ROW_1_RST = 64'h0000_0000_1000_0000;
    localparam logic [CFG_W-1:0] WORLD_ROW_2_RST = 64'h0000_1000_0000_0000;
    localparam logic [CFG_W-1:0] PROJ_XY_RST     = 64'h0000_1000_0000_1000;
    localparam logic [15:0]      PROJ_W_RST      = 16'hF000;

endpackage

@@ rtl/vertex_transform_project_core.sv @@
// Vertex transform, near test, perspective projection and pixel mapping pipeline.
//
// Input stream s_*: one Q8.8 vertex per transfer. Output stream m_*: one
// result per vertex, in order: pixel column, pixel row, visible flag.
// Configuration: cfg_we/cfg_index/cfg_data write one register per cycle;
// write only while no vertex is in flight.
// Pipeline: 6 transform and projection stages, one overflow test stage,
// 15 restoring divide stages, output register. Throughput: one vertex per
// cycle while the output is not stalled; the 15-step divider is fully
// pipelined, one quotient bit per stage, x and y lanes in parallel.
// Stall: the whole pipeline holds while m_tvalid is high and m_tready low;
// s_tready drops in the same cycle, nothing is lost or repeated.
// Reset: all stage valid bits and m_tvalid clear; registers take their
// identity defaults (w = -z projection).
// Rejected vertices (near limit or zero w) leave as zero with visible low.
module vertex_transform_project_core
    import vtp_pkg::*;
#(
    parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [IDX_W-1:0]   cfg_index,
    input  logic [CFG_W-1:0]   cfg_data,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [47:0]        s_tdata,   // vert_x, vert_y, vert_z
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [39:0]        m_tdata    // screen_x, screen_y, visible, zero pad
);

    localparam int SCREEN_MAX = (SCREEN_WIDTH > SCREEN_HEIGHT) ? SCREEN_WIDTH : SCREEN_HEIGHT;
    localparam int SCALE_W    = $clog2(SCREEN_MAX + 1) + 1;
    localparam int NUM_W      = NDC_W + SCALE_W;
    localparam int DIV_W      = NUM_W + Q_BITS;
    localparam logic signed [SCALE_W-1:0] SW_C = SCALE_W'(SCREEN_WIDTH);
    localparam logic signed [SCALE_W-1:0] SH_C = SCALE_W'(SCREEN_HEIGHT);

    logic [CFG_W-1:0] row_reg [3];
    logic [CFG_W-1:0] proj_xy_reg;
    logic [15:0]      proj_w_reg;

    logic adv;

    // stage 1
    logic                        v1_reg;
    logic signed [PROD_W-1:0]    p1_reg [3][3];
    logic signed [TRANS_W-1:0]   t1_reg [3];
    // stage 2
    logic                        v2_reg;
    logic signed [CAM_W-1:0]     c2_reg [3];
    // stage 3
    logic                        v3_reg;
    logic signed [PROJ_W-1:0]    pp3_reg [4];
    logic signed [PROJ_W-1:0]    pw3_reg;
    logic                        near3_reg;
    // stage 4
    logic                        v4_reg;
    logic signed [NDC_W-1:0]     nx4_reg;
    logic signed [NDC_W-1:0]     ny4_reg;
    logic signed [NDC_W-1:0]     den4_reg;
    logic                        rej4_reg;
    // stage 5
    logic                        v5_reg;
    logic signed [NUM_W-1:0]     nx5_reg;
    logic signed [NUM_W-1:0]     ny5_reg;
    logic signed [NDC_W-1:0]     den5_reg;
    logic                        rej5_reg;
    // stage 6
    logic                        v6_reg;
    logic [NUM_W-1:0]            a6_reg [2];
    logic                        neg6_reg [2];
    logic [NDC_W-1:0]            den6_reg;
    logic                        rej6_reg;
    // divide pipeline, index 0 is the overflow test stage
    logic                        dv_reg   [Q_BITS+1];
    logic [NUM_W-1:0]            rem_reg  [Q_BITS+1][2];
    logic [Q_BITS-1:0]           quo_reg  [Q_BITS+1][2];
    logic                        ovf_reg  [Q_BITS+1][2];
    logic                        neg_reg  [Q_BITS+1][2];
    logic [NDC_W-1:0]            dden_reg [Q_BITS+1];
    logic                        drej_reg [Q_BITS+1];
    // output
    logic                        m_tvalid_reg;
    logic signed [15:0]          sx_reg;
    logic signed [15:0]          sy_reg;
    logic                        vis_reg;

    logic signed [15:0] sx_next;
    logic signed [15:0] sy_next;

    assign adv      = !m_tvalid_reg || m_tready;
    assign s_tready = adv;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'd0, vis_reg, sy_reg, sx_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg[0]  <= WORLD_ROW_0_RST;
            row_reg[1]  <= WORLD_ROW_1_RST;
            row_reg[2]  <= WORLD_ROW_2_RST;
            proj_xy_reg <= PROJ_XY_RST;
            proj_w_reg  <= PROJ_W_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_WORLD_ROW_0: row_reg[0]  <= cfg_data;
                CFG_WORLD_ROW_1: row_reg[1]  <= cfg_data;
                CFG_WORLD_ROW_2: row_reg[2]  <= cfg_data;
                CFG_PROJ_XY:     proj_xy_reg <= cfg_data;
                CFG_PROJ_W:      proj_w_reg  <= cfg_data[15:0];
                default:         ;
            endcase
        end
    end

    // valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            v3_reg       <= 1'b0;
            v4_reg       <= 1'b0;
            v5_reg       <= 1'b0;
            v6_reg       <= 1'b0;
            m_tvalid_reg <= 1'b0;
            for (int j = 0; j <= Q_BITS; j++)
            begin
                dv_reg[j] <= 1'b0;
            end
        end
        else if (adv)
        begin
            v1_reg    <= s_tvalid;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            v4_reg    <= v3_reg;
            v5_reg    <= v4_reg;
            v6_reg    <= v5_reg;
            dv_reg[0] <= v6_reg;
            for (int j = 1; j <= Q_BITS; j++)
            begin
                dv_reg[j] <= dv_reg[j-1];
            end
            m_tvalid_reg <= dv_reg[Q_BITS];
        end
    end

    // transform and projection stages
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int r = 0; r < 3; r++)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    p1_reg[r][k] <= $signed(row_reg[r][16*k +: 16])
                                  * $signed(s_tdata[16*k +: 16]);
                end
                t1_reg[r] <= {$signed(row_reg[r][63:48]), 12'd0};
                c2_reg[r] <= CAM_W'(p1_reg[r][0]) + CAM_W'(p1_reg[r][1])
                           + CAM_W'(p1_reg[r][2]) + CAM_W'(t1_reg[r]);
            end

            pp3_reg[0] <= $signed(proj_xy_reg[15:0])  * c2_reg[0];
            pp3_reg[1] <= $signed(proj_xy_reg[31:16]) * c2_reg[2];
            pp3_reg[2] <= $signed(proj_xy_reg[47:32]) * c2_reg[1];
            pp3_reg[3] <= $signed(proj_xy_reg[63:48]) * c2_reg[2];
            pw3_reg    <= $signed(proj_w_reg) * c2_reg[2];
            near3_reg  <= (c2_reg[2] >= NEAR_Q20);

            nx4_reg  <= NDC_W'(pp3_reg[0]) + NDC_W'(pp3_reg[1]) + NDC_W'(pw3_reg);
            ny4_reg  <= NDC_W'(pw3_reg) - NDC_W'(pp3_reg[2]) - NDC_W'(pp3_reg[3]);
            den4_reg <= NDC_W'(pw3_reg) + NDC_W'(pw3_reg);
            rej4_reg <= near3_reg || (pw3_reg == '0);

            nx5_reg  <= nx4_reg * SW_C;
            ny5_reg  <= ny4_reg * SH_C;
            den5_reg <= den4_reg;
            rej5_reg <= rej4_reg;

            a6_reg[0]   <= nx5_reg[NUM_W-1] ? NUM_W'(-nx5_reg) : NUM_W'(nx5_reg);
            a6_reg[1]   <= ny5_reg[NUM_W-1] ? NUM_W'(-ny5_reg) : NUM_W'(ny5_reg);
            neg6_reg[0] <= nx5_reg[NUM_W-1] ^ den5_reg[NDC_W-1];
            neg6_reg[1] <= ny5_reg[NUM_W-1] ^ den5_reg[NDC_W-1];
            den6_reg    <= den5_reg[NDC_W-1] ? NDC_W'(-den5_reg) : NDC_W'(den5_reg);
            rej6_reg    <= rej5_reg;
        end
    end

    // overflow test and restoring divide, one quotient bit per stage
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dden_reg[0] <= den6_reg;
            drej_reg[0] <= rej6_reg;
            for (int l = 0; l < 2; l++)
            begin
                rem_reg[0][l] <= a6_reg[l];
                quo_reg[0][l] <= '0;
                neg_reg[0][l] <= neg6_reg[l];
                ovf_reg[0][l] <= DIV_W'(a6_reg[l]) >= (DIV_W'(den6_reg) << Q_BITS);
            end
            for (int j = 1; j <= Q_BITS; j++)
            begin
                dden_reg[j] <= dden_reg[j-1];
                drej_reg[j] <= drej_reg[j-1];
                for (int l = 0; l < 2; l++)
                begin
                    neg_reg[j][l] <= neg_reg[j-1][l];
                    ovf_reg[j][l] <= ovf_reg[j-1][l];
                    if (DIV_W'(rem_reg[j-1][l]) >= (DIV_W'(dden_reg[j-1]) << (Q_BITS - j)))
                    begin
                        rem_reg[j][l] <= NUM_W'(DIV_W'(rem_reg[j-1][l])
                                       - (DIV_W'(dden_reg[j-1]) << (Q_BITS - j)));
                        quo_reg[j][l] <= quo_reg[j-1][l] | (Q_BITS'(1) << (Q_BITS - j));
                    end
                    else
                    begin
                        rem_reg[j][l] <= rem_reg[j-1][l];
                        quo_reg[j][l] <= quo_reg[j-1][l];
                    end
                end
            end
        end
    end

    function automatic logic signed [15:0] sat_pix(input logic ovf, input logic neg,
                                                   input logic [Q_BITS-1:0] q);
        logic signed [15:0] mag;
        mag = $signed({1'b0, q});
        priority if (ovf && neg)
            return 16'sh8000;
        else if (ovf)
            return 16'sh7FFF;
        else if (neg)
            return -mag;
        else
            return mag;
    endfunction

    always_comb
    begin
        sx_next = sat_pix(ovf_reg[Q_BITS][0], neg_reg[Q_BITS][0], quo_reg[Q_BITS][0]);
        sy_next = sat_pix(ovf_reg[Q_BITS][1], neg_reg[Q_BITS][1], quo_reg[Q_BITS][1]);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sx_reg  <= drej_reg[Q_BITS] ? 16'sd0 : sx_next;
            sy_reg  <= drej_reg[Q_BITS] ? 16'sd0 : sy_next;
            vis_reg <= !drej_reg[Q_BITS];
        end
    end

`ifndef SYNTHESIS
    a_hidden_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[32] |-> m_tdata[31:0] == 32'd0)
        else $error("rejected vertex carries nonzero coordinates");

    a_stall_freezes_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(dv_reg[Q_BITS]) && $stable(v1_reg) && $stable(quo_reg[Q_BITS][0]))
        else $error("pipeline moved during output stall");

    a_ready_follows_output: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input taken while output stalled");
`endif

endmodule
